### sv/kdb_pkg.sv
package kdb_pkg;

	// Default number of keys scanned per tick.
	localparam int KEYS_DEF = 4;

	// Configuration register widths and reset values.
	localparam int DEB_W  = 8;
	localparam int HOLD_W = 16;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd3;
	localparam logic [HOLD_W-1:0] LONG_RESET     = 16'd100;

	// Configuration port: index and data widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG     = 2'd1;

	// Limits shared by every key cell.
	typedef struct packed {
		logic [DEB_W-1:0]  debounce;
		logic [HOLD_W-1:0] long_limit;
	} key_cfg_t;

	// What one key reports for one tick.
	typedef struct packed {
		logic stable;
		logic short_p;
		logic long_p;
	} key_evt_t;

endpackage

### sv/kdb_if.sv
// Input channel: one scan tick per beat.
interface kdb_in_if import kdb_pkg::*; #(parameter int KEYS = KEYS_DEF) ();
	logic            valid;
	logic            ready;
	logic [KEYS-1:0] raw_levels;

	modport source (output valid, output raw_levels, input ready);
	modport sink   (input valid, input raw_levels, output ready);
endinterface

// Result channel: debounced levels and press pulses, one beat per tick.
interface kdb_out_if import kdb_pkg::*; #(parameter int KEYS = KEYS_DEF) ();
	logic            valid;
	logic            ready;
	logic [KEYS-1:0] stable_levels;
	logic [KEYS-1:0] short_press;
	logic [KEYS-1:0] long_press;

	modport source (output valid, output stable_levels, output short_press,
		output long_press, input ready);
	modport sink   (input valid, input stable_levels, input short_press,
		input long_press, output ready);
endinterface

// Configuration write channel.
interface kdb_cfg_if import kdb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/kdb_key.sv
module kdb_key import kdb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  logic     lvl,
	input  key_cfg_t cfg,
	output key_evt_t evt
);

	logic              last_raw_q;
	logic              stable_q;
	logic [DEB_W-1:0]  settle_q;
	logic [HOLD_W-1:0] hold_q;
	logic              done_q;

	logic              last_raw_n;
	logic              stable_n;
	logic [DEB_W-1:0]  settle_n;
	logic [HOLD_W-1:0] hold_mid;
	logic [HOLD_W-1:0] hold_n;
	logic              done_mid;
	logic              done_n;
	logic              short_n;
	logic              long_n;

	// Settle counter and acceptance of a new stable level.
	always_comb begin
		last_raw_n = last_raw_q;
		stable_n   = stable_q;
		settle_n   = settle_q;
		hold_mid   = hold_q;
		done_mid   = done_q;
		short_n    = 1'b0;
		if (lvl != last_raw_q) begin
			last_raw_n = lvl;
			settle_n   = '0;
		end else if (settle_q < cfg.debounce) begin
			settle_n = settle_q + 1'b1;
			if (settle_n == cfg.debounce && stable_q != lvl) begin
				stable_n = lvl;
				short_n  = lvl && (hold_q < cfg.long_limit) && !done_q;
				hold_mid = '0;
				done_mid = 1'b0;
			end
		end
	end

	// Hold counter while the key is stably pressed.
	always_comb begin
		hold_n = hold_mid;
		done_n = done_mid;
		long_n = 1'b0;
		if (!stable_n && hold_mid < cfg.long_limit) begin
			hold_n = hold_mid + 1'b1;
			if (hold_n == cfg.long_limit) begin
				long_n = 1'b1;
				done_n = 1'b1;
			end
		end
	end

	// Key state advances once per tick that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b1;
			stable_q   <= 1'b1;
			settle_q   <= '0;
			hold_q     <= '0;
			done_q     <= 1'b0;
		end else if (step) begin
			last_raw_q <= last_raw_n;
			stable_q   <= stable_n;
			settle_q   <= settle_n;
			hold_q     <= hold_n;
			done_q     <= done_n;
		end
	end

	assign evt.stable  = stable_n;
	assign evt.short_p = short_n;
	assign evt.long_p  = long_n;

endmodule

### sv/key_debounce_short_long_press.sv
// Key debouncer with short and long press detection for KEYS active-low keys.
// Each beat on the keys channel is one scan tick carrying the raw pin levels,
// bit k for key k, where 0 means pressed. Each tick gives exactly one beat on
// the events channel: the debounced levels after the tick, a short_press pulse
// for a key whose release was accepted before its long press fired, and a
// long_press pulse on the tick a key's hold counter reaches the limit.
// The cfg channel writes debounce_count (index 0) and long_press_count
// (index 1); it is always ready and writes take effect from the next tick.
// An accepted tick waits in the input register, then the per-key settle and
// hold counters update as the tick moves into the result register. Throughput
// is one tick per cycle while the receiver keeps taking result beats.
// At reset every key reads released, all counters are zero and the registers
// hold 3 and 100. When the receiver stalls, the result beat is held, one more
// tick waits in the input register, and then keys.ready drops until the
// result is taken.
module key_debounce_short_long_press import kdb_pkg::*; #(
	parameter int KEYS = KEYS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kdb_in_if.sink    keys,
	kdb_out_if.source events,
	kdb_cfg_if.sink   cfg
);

	logic [DEB_W-1:0]  debounce_q;
	logic [HOLD_W-1:0] long_limit_q;
	key_cfg_t          lim;

	logic            vld_s1;
	logic [KEYS-1:0] raw_s1;
	logic            vld_s2;
	logic [KEYS-1:0] stable_s2;
	logic [KEYS-1:0] short_s2;
	logic [KEYS-1:0] long_s2;

	logic            advance;
	logic            step;
	key_evt_t        evt [KEYS];
	logic [KEYS-1:0] stable_c;
	logic [KEYS-1:0] short_c;
	logic [KEYS-1:0] long_c;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_limit_q <= LONG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEBOUNCE: debounce_q   <= cfg.data[DEB_W-1:0];
				REG_LONG:     long_limit_q <= cfg.data[HOLD_W-1:0];
				default:      ;
			endcase
		end
	end

	assign lim.debounce   = debounce_q;
	assign lim.long_limit = long_limit_q;

	// Flow control: the result register frees up when empty or being taken.
	assign advance    = !vld_s2 || events.ready;
	assign step       = vld_s1 && advance;
	assign keys.ready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (keys.ready) begin
			vld_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.ready && keys.valid) begin
			raw_s1 <= keys.raw_levels;
		end
	end

	// One cell per key.
	for (genvar k = 0; k < KEYS; k++) begin : g_key
		kdb_key u_key (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.lvl    (raw_s1[k]),
			.cfg    (lim),
			.evt    (evt[k])
		);
		assign stable_c[k] = evt[k].stable;
		assign short_c[k]  = evt[k].short_p;
		assign long_c[k]   = evt[k].long_p;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			stable_s2 <= stable_c;
			short_s2  <= short_c;
			long_s2   <= long_c;
		end
	end

	assign events.valid         = vld_s2;
	assign events.stable_levels = stable_s2;
	assign events.short_press   = short_s2;
	assign events.long_press    = long_s2;

	// A key never pulses short and long on the same tick.
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> (events.short_press & events.long_press) == '0)
		else $error("short and long press on the same key");

	// A short press is reported only for a key that now reads released.
	a_short_rel: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> (events.short_press & ~events.stable_levels) == '0)
		else $error("short press on a pressed key");

	// A long press is reported only for a key that reads pressed.
	a_long_prs: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> (events.long_press & events.stable_levels) == '0)
		else $error("long press on a released key");

	// Input back-pressure only while a full pipeline is stalled downstream.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!keys.ready |-> (vld_s1 && events.valid && !events.ready))
		else $error("input stalled without downstream stall");

endmodule

### sim/tb.sv
module tb;
	import kdb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS = KEYS_DEF;

	// Register indexes past the end of the list; the block must ignore writes to them.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE3 = 2'd3;

	// One result beat as the scoreboard holds it.
	typedef struct packed {
		logic [KEYS-1:0] stable;
		logic [KEYS-1:0] shorts;
		logic [KEYS-1:0] longs;
	} scan_result_t;

	localparam scan_result_t AT_REST = '{stable: '1, shorts: '0, longs: '0};

	// Directed plan: either a register write or a run of identical scan ticks.
	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [KEYS-1:0]        pins;
		logic [7:0]             reps;
		logic                   typed;
		scan_result_t           want;
	} plan_row_t;

	localparam int PLAN_LEN = 23;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// Straight after reset every key reads released and nothing pulses.
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hF, 8'd1, 1'b1, AT_REST},
		'{ROW_CFG,  REG_DEBOUNCE, 16'd1,     4'hF, 8'd0, 1'b0, '0},
		'{ROW_CFG,  REG_LONG,     16'd3,     4'hF, 8'd0, 1'b0, '0},
		// Key 0 held to a long press, then released with no short pulse.
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hE, 8'd4, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hF, 8'd2, 1'b0, '0},
		// All keys tapped briefly: short pulses on release.
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h0, 8'd2, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hF, 8'd2, 1'b0, '0},
		// Writes beyond the register list.
		'{ROW_CFG,  REG_SPARE2,   16'hFFFF,  4'hF, 8'd0, 1'b0, '0},
		'{ROW_CFG,  REG_SPARE3,   16'h1234,  4'hF, 8'd0, 1'b0, '0},
		// Limit lowered beneath the hold count while pressed.
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h0, 8'd3, 1'b0, '0},
		'{ROW_CFG,  REG_LONG,     16'd1,     4'hF, 8'd0, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h0, 8'd1, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hF, 8'd2, 1'b0, '0},
		// Limit raised after the long press has fired.
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h0, 8'd2, 1'b0, '0},
		'{ROW_CFG,  REG_LONG,     16'd3,     4'hF, 8'd0, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h0, 8'd2, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hF, 8'd2, 1'b0, '0},
		// With a debounce count of zero nothing is ever accepted.
		'{ROW_CFG,  REG_DEBOUNCE, 16'd0,     4'hF, 8'd0, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h0, 8'd3, 1'b0, '0},
		// Upper data bits are dropped for the debounce register.
		'{ROW_CFG,  REG_DEBOUNCE, 16'hFF01,  4'hF, 8'd0, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'hF, 8'd2, 1'b0, '0},
		'{ROW_CFG,  REG_LONG,     16'hFFFF,  4'hF, 8'd0, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE, 16'd0,     4'h5, 8'd3, 1'b0, '0}
	};

	// Random phases: register settings and the number of scan ticks to spend on each.
	typedef struct packed {
		logic [CFG_DATA_W-1:0] deb_data;
		logic [CFG_DATA_W-1:0] lim_data;
		logic [15:0]           ticks;
	} phase_t;

	localparam int PHASE_LEN = 10;
	localparam phase_t PHASES [PHASE_LEN] = '{
		'{16'd3,    16'd100, 16'd120},
		'{16'd1,    16'd1,   16'd120},
		'{16'd2,    16'd5,   16'd120},
		'{16'd4,    16'd20,  16'd120},
		'{16'h5A1F, 16'd8,   16'd200},
		'{16'd0,    16'd10,  16'd60},
		'{16'd3,    16'd0,   16'd100},
		'{16'd2,    16'd60,  16'd80},
		'{16'd2,    16'd7,   16'd80},
		'{16'd2,    16'd200, 16'd120}
	};

	localparam int LONG_HOLD_TICKS = 96;

	logic clk;
	logic arst_n;

	kdb_in_if  #(.KEYS(KEYS)) keys_ch ();
	kdb_out_if #(.KEYS(KEYS)) events_ch ();
	kdb_cfg_if                cfg_ch ();

	key_debounce_short_long_press #(.KEYS(KEYS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (keys_ch),
		.events (events_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the registers and of the per-key debounce state.
	key_cfg_t          cfg_shadow;
	logic              last_pin   [KEYS];
	logic              settled    [KEYS];
	logic [DEB_W-1:0]  settle_cnt [KEYS];
	logic [HOLD_W-1:0] hold_cnt   [KEYS];
	logic              long_fired [KEYS];

	scan_result_t pending_events [$];

	int  mismatches;
	int  ticks_sent;
	int  beats_checked;
	int  short_seen;
	int  long_seen;
	int  reg_writes;
	bit  no_gaps;
	bit  holdoff_done;
	int  holdoff_left;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#30_000_000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// One scan tick through the shadow state; mirrors the per-key order of the block.
	function automatic scan_result_t scan_tick(input logic [KEYS-1:0] pins);
		scan_result_t r;
		logic lvl;
		r = '0;
		for (int k = 0; k < KEYS; k++) begin
			lvl = pins[k];
			if (lvl != last_pin[k]) begin
				last_pin[k] = lvl;
				settle_cnt[k] = '0;
			end else if (settle_cnt[k] < cfg_shadow.debounce) begin
				settle_cnt[k] = settle_cnt[k] + 1'b1;
				if (settle_cnt[k] == cfg_shadow.debounce && settled[k] != lvl) begin
					settled[k] = lvl;
					if (lvl && hold_cnt[k] < cfg_shadow.long_limit && !long_fired[k])
						r.shorts[k] = 1'b1;
					hold_cnt[k] = '0;
					long_fired[k] = 1'b0;
				end
			end
			// The hold counter runs only while the debounced level is pressed.
			if (!settled[k] && hold_cnt[k] < cfg_shadow.long_limit) begin
				hold_cnt[k] = hold_cnt[k] + 1'b1;
				if (hold_cnt[k] == cfg_shadow.long_limit) begin
					r.longs[k] = 1'b1;
					long_fired[k] = 1'b1;
				end
			end
			r.stable[k] = settled[k];
		end
		return r;
	endfunction

	// Offer one scan tick, with a random gap in front, and record its expected beat.
	task automatic send_tick(input logic [KEYS-1:0] pins, input logic typed = 1'b0,
		input scan_result_t want = '0);
		scan_result_t predicted;
		while (!no_gaps && $urandom_range(0, 99) < 35) begin
			keys_ch.valid <= 1'b0;
			@(posedge clk);
		end
		keys_ch.valid      <= 1'b1;
		keys_ch.raw_levels <= pins;
		@(posedge clk);
		while (!keys_ch.ready) @(posedge clk);
		predicted = scan_tick(pins);
		pending_events.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	// Hold the input back until every outstanding result beat has been taken.
	task automatic settle_idle();
		keys_ch.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_DEBOUNCE: cfg_shadow.debounce   = data[DEB_W-1:0];
			REG_LONG:     cfg_shadow.long_limit = data[HOLD_W-1:0];
			default:      ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random key activity: mostly bounced presses and releases held for lengths
	// around the debounce and long press counts, with some pure noise. The last
	// hold of a phase is cut to the budget left, but bounce and noise can overrun.
	task automatic run_phase(input int budget);
		int sent;
		int dice;
		int bounce;
		int len;
		int deb;
		int lim;
		logic [KEYS-1:0] target;
		sent = 0;
		target = '1;
		deb = cfg_shadow.debounce;
		lim = cfg_shadow.long_limit;
		while (sent < budget) begin
			dice = $urandom_range(0, 99);
			if (dice < 15) begin
				len = $urandom_range(1, 6);
				repeat (len) send_tick(KEYS'($urandom));
				sent += len;
			end else begin
				if (dice < 75)
					target ^= KEYS'($urandom_range(1, (1 << KEYS) - 1));
				else
					target = KEYS'($urandom);
				bounce = $urandom_range(0, 3);
				repeat (bounce) send_tick(KEYS'($urandom));
				sent += bounce;
				dice = $urandom_range(0, 9);
				if (dice < 2)
					len = $urandom_range(1, deb + 1);
				else if (dice < 6 || lim > 300)
					len = deb + 1 + $urandom_range(0, (lim < 300) ? lim : 300);
				else
					len = deb + 1 + lim + $urandom_range(0, 4);
				if (len > budget - sent)
					len = (budget > sent) ? budget - sent : 1;
				repeat (len) send_tick(target);
				sent += len;
			end
		end
	endtask

	// Result side: check each beat against the oldest expectation, then choose ready.
	initial begin
		events_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (events_ch.valid && events_ch.ready) begin
				if (pending_events.size() == 0) begin
					log_mismatch($sformatf("unexpected beat stable=%h short=%h long=%h",
						events_ch.stable_levels, events_ch.short_press, events_ch.long_press));
				end else begin
					scan_result_t want;
					want = pending_events.pop_front();
					if (events_ch.stable_levels !== want.stable)
						log_mismatch($sformatf("beat %0d stable_levels %h, expected %h",
							beats_checked, events_ch.stable_levels, want.stable));
					if (events_ch.short_press !== want.shorts)
						log_mismatch($sformatf("beat %0d short_press %h, expected %h",
							beats_checked, events_ch.short_press, want.shorts));
					if (events_ch.long_press !== want.longs)
						log_mismatch($sformatf("beat %0d long_press %h, expected %h",
							beats_checked, events_ch.long_press, want.longs));
					short_seen += $countones(want.shorts);
					long_seen  += $countones(want.longs);
				end
				beats_checked++;
				// Once in the run, stall for a long stretch so the block backs up.
				if (beats_checked == 300 && !holdoff_done) begin
					holdoff_done = 1'b1;
					holdoff_left = 50;
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				events_ch.ready <= 1'b0;
			end else begin
				events_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int drain_wait;
		arst_n             <= 1'b0;
		keys_ch.valid      <= 1'b0;
		keys_ch.raw_levels <= '1;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= REG_DEBOUNCE;
		cfg_ch.data        <= '0;
		cfg_shadow.debounce   = DEBOUNCE_RESET;
		cfg_shadow.long_limit = LONG_RESET;
		for (int k = 0; k < KEYS; k++) begin
			last_pin[k]   = 1'b1;
			settled[k]    = 1'b1;
			settle_cnt[k] = '0;
			hold_cnt[k]   = '0;
			long_fired[k] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan.
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				settle_idle();
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else begin
				for (int n = 0; n < PLAN[i].reps; n++)
					send_tick(PLAN[i].pins, PLAN[i].typed, PLAN[i].want);
			end
		end

		// Random phases; keys may stay pressed across a change of limits.
		for (int p = 0; p < PHASE_LEN; p++) begin
			settle_idle();
			write_reg(REG_DEBOUNCE, PHASES[p].deb_data);
			write_reg(REG_LONG, PHASES[p].lim_data);
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
					CFG_DATA_W'($urandom));
			run_phase(PHASES[p].ticks);
		end

		// Gap-free stretch: every key held past a long press, then released.
		settle_idle();
		no_gaps = 1'b1;
		write_reg(REG_DEBOUNCE, 16'd1);
		write_reg(REG_LONG, 16'd80);
		repeat (LONG_HOLD_TICKS) send_tick('0);
		repeat (4) send_tick('1);
		no_gaps = 1'b0;

		// Drain, then watch for any stray beat before the summary.
		keys_ch.valid <= 1'b0;
		drain_wait = 0;
		while (pending_events.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (pending_events.size() != 0)
			log_mismatch($sformatf("%0d expected beats never arrived", pending_events.size()));

		$display("Covered %0d scan ticks, %0d result beats, %0d register writes.",
			ticks_sent, beats_checked, reg_writes);
		$display("Expected %0d short and %0d long press pulses; %0d mismatches.",
			short_seen, long_seen, mismatches);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

### key_debounce_short_long_press.f
sv/kdb_pkg.sv
sv/kdb_if.sv
sv/kdb_key.sv
sv/key_debounce_short_long_press.sv
sim/tb.sv
